// ===== src/assert_macros.svh =====
// Shared assertion wrappers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge out of reset
`define CNRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cnrf assertion failed");

// Consequent must hold in the cycle after the antecedent
`define CNRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cnrf assertion failed");

`endif

// ===== src/cnrf_pkg.sv =====
package cnrf_pkg;

  localparam int W          = 32;
  localparam int FB         = 16;
  localparam int ITER_W     = 6;
  localparam int LIM_W      = 7;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int PC_W       = 4;
  localparam int DIV_STEPS  = W + FB;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int OUT_DATA_W = 168;

  localparam logic [PC_W-1:0]  PC_LAST   = PC_W'(15);
  localparam logic [LIM_W-1:0] LIM_MAX   = LIM_W'(64);
  localparam logic [LIM_W-1:0] LIM_MIN   = LIM_W'(1);

  typedef enum logic [2:0] {
    REG_COEF_CUBIC    = 3'd0,
    REG_COEF_SQUARE   = 3'd1,
    REG_COEF_LINEAR   = 3'd2,
    REG_COEF_CONSTANT = 3'd3,
    REG_STEP_TOL      = 3'd4,
    REG_ITER_LIMIT    = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_RUN   = 3'd0,
    ST_CONV  = 3'd1,
    ST_LIMIT = 3'd2,
    ST_ZERO  = 3'd3,
    ST_OVF   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SEQ, S_CHECK, S_DIV, S_QUOT, S_RES, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    UOP_NOP, UOP_MUL, UOP_ADD
  } uop_kind_e;

  typedef enum logic [3:0] {
    SRC_X, SRC_X2, SRC_X3, SRC_F, SRC_FD, SRC_T, SRC_U, SRC_G, SRC_H,
    SRC_A, SRC_B, SRC_C, SRC_D
  } src_e;

  typedef enum logic [2:0] {
    DST_X2, DST_X3, DST_F, DST_FD, DST_T, DST_U, DST_G, DST_H
  } dst_e;

  typedef struct packed {
    uop_kind_e kind;
    src_e      sa;
    src_e      sb;
    dst_e      dst;
  } uop_t;

  typedef struct packed {
    logic              load;
    logic              uop_en;
    uop_t              uop;
    logic              div_start;
    logic              div_step;
    logic              quot;
    logic              res;
    logic              advance;
    logic [ITER_W-1:0] iter;
    logic              last_iter;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fd_zero;
    logic res_last;
  } dp_stat_t;

  // Polynomial and slope schedule; a product is registered in prod_q, then written to its destination
  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      4'd0:    u = '{UOP_MUL, SRC_X,  SRC_X,  DST_X2};
      4'd1:    u = '{UOP_NOP, SRC_X,  SRC_X,  DST_X2};
      4'd2:    u = '{UOP_MUL, SRC_X2, SRC_X,  DST_X3};
      4'd3:    u = '{UOP_MUL, SRC_A,  SRC_X2, DST_T};
      4'd4:    u = '{UOP_MUL, SRC_A,  SRC_X3, DST_F};
      4'd5:    u = '{UOP_MUL, SRC_B,  SRC_X2, DST_G};
      4'd6:    u = '{UOP_MUL, SRC_C,  SRC_X,  DST_H};
      4'd7:    u = '{UOP_ADD, SRC_F,  SRC_G,  DST_F};
      4'd8:    u = '{UOP_ADD, SRC_F,  SRC_H,  DST_F};
      4'd9:    u = '{UOP_ADD, SRC_F,  SRC_D,  DST_F};
      4'd10:   u = '{UOP_MUL, SRC_B,  SRC_X,  DST_U};
      4'd11:   u = '{UOP_ADD, SRC_T,  SRC_T,  DST_FD};
      4'd12:   u = '{UOP_ADD, SRC_FD, SRC_T,  DST_FD};
      4'd13:   u = '{UOP_ADD, SRC_U,  SRC_U,  DST_U};
      4'd14:   u = '{UOP_ADD, SRC_FD, SRC_U,  DST_FD};
      4'd15:   u = '{UOP_ADD, SRC_FD, SRC_C,  DST_FD};
      default: u = '{UOP_NOP, SRC_X,  SRC_X,  DST_X2};
    endcase
    return u;
  endfunction

endpackage

// ===== src/cnrf_ctrl.sv =====
module cnrf_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic [cnrf_pkg::LIM_W-1:0]   iter_limit_i,
  input  cnrf_pkg::dp_stat_t           stat_i,
  output cnrf_pkg::ctrl_cmd_t          cmd_o
);

  cnrf_pkg::state_e                    state_q, state_d;
  logic [cnrf_pkg::PC_W-1:0]           pc_q, pc_d;
  logic [cnrf_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [cnrf_pkg::ITER_W-1:0]         iter_q, iter_d;
  logic [cnrf_pkg::LIM_W-1:0]          lim;

  always_comb begin
    if (iter_limit_i == '0) begin
      lim = cnrf_pkg::LIM_MIN;
    end else if (iter_limit_i > cnrf_pkg::LIM_MAX) begin
      lim = cnrf_pkg::LIM_MAX;
    end else begin
      lim = iter_limit_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cnrf_pkg::S_IDLE:  if (in_valid_i) state_d = cnrf_pkg::S_SEQ;
      cnrf_pkg::S_SEQ:   if (pc_q == cnrf_pkg::PC_LAST) state_d = cnrf_pkg::S_CHECK;
      cnrf_pkg::S_CHECK: state_d = stat_i.fd_zero ? cnrf_pkg::S_RES : cnrf_pkg::S_DIV;
      cnrf_pkg::S_DIV: begin
        if (cnt_q == cnrf_pkg::DIV_CNT_W'(cnrf_pkg::DIV_STEPS - 1)) begin
          state_d = cnrf_pkg::S_QUOT;
        end
      end
      cnrf_pkg::S_QUOT:  state_d = cnrf_pkg::S_RES;
      cnrf_pkg::S_RES:   state_d = cnrf_pkg::S_OUT;
      cnrf_pkg::S_OUT: begin
        if (out_ready_i) begin
          state_d = stat_i.res_last ? cnrf_pkg::S_IDLE : cnrf_pkg::S_SEQ;
        end
      end
      default:           state_d = cnrf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pc_d   = (state_q == cnrf_pkg::S_SEQ) ? pc_q + 1'b1 : '0;
    cnt_d  = (state_q == cnrf_pkg::S_DIV) ? cnt_q + 1'b1 : '0;
    iter_d = iter_q;
    if (state_q == cnrf_pkg::S_IDLE) begin
      iter_d = '0;
    end else if (state_q == cnrf_pkg::S_OUT && out_ready_i && !stat_i.res_last) begin
      iter_d = iter_q + 1'b1;
    end
  end

  always_comb begin
    in_ready_o        = (state_q == cnrf_pkg::S_IDLE);
    out_valid_o       = (state_q == cnrf_pkg::S_OUT);
    cmd_o.load        = (state_q == cnrf_pkg::S_IDLE) && in_valid_i;
    cmd_o.uop_en      = (state_q == cnrf_pkg::S_SEQ);
    cmd_o.uop         = cnrf_pkg::uop_rom(pc_q);
    cmd_o.div_start   = (state_q == cnrf_pkg::S_CHECK) && !stat_i.fd_zero;
    cmd_o.div_step    = (state_q == cnrf_pkg::S_DIV);
    cmd_o.quot        = (state_q == cnrf_pkg::S_QUOT);
    cmd_o.res         = (state_q == cnrf_pkg::S_RES);
    cmd_o.advance     = (state_q == cnrf_pkg::S_OUT) && out_ready_i && !stat_i.res_last;
    cmd_o.iter        = iter_q;
    cmd_o.last_iter   = ((cnrf_pkg::LIM_W'(iter_q) + 1'b1) == lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cnrf_pkg::S_IDLE;
      pc_q    <= '0;
      cnt_q   <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      iter_q  <= iter_d;
    end
  end

endmodule

// ===== src/cnrf_dp.sv =====
module cnrf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cnrf_pkg::ctrl_cmd_t               cmd_i,
  input  logic signed [cnrf_pkg::W-1:0]     start_x_i,
  input  logic signed [cnrf_pkg::W-1:0]     coef_cubic_i,
  input  logic signed [cnrf_pkg::W-1:0]     coef_square_i,
  input  logic signed [cnrf_pkg::W-1:0]     coef_linear_i,
  input  logic signed [cnrf_pkg::W-1:0]     coef_constant_i,
  input  logic [cnrf_pkg::W-2:0]            step_tol_i,
  output cnrf_pkg::dp_stat_t                stat_o,
  output logic [cnrf_pkg::ITER_W-1:0]       iteration_o,
  output logic signed [cnrf_pkg::W-1:0]     x_before_o,
  output logic signed [cnrf_pkg::W-1:0]     f_value_o,
  output logic signed [cnrf_pkg::W-1:0]     f_slope_o,
  output logic signed [cnrf_pkg::W-1:0]     x_after_o,
  output logic [cnrf_pkg::W-2:0]            step_size_o,
  output cnrf_pkg::status_e                 status_o
);

  localparam int W  = cnrf_pkg::W;
  localparam int FB = cnrf_pkg::FB;
  localparam int PW = 2 * W;
  localparam int RW = 2 * W - FB;
  localparam int NW = W + FB;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] HALF     = PW'(1) << (FB - 1);
  localparam logic [RW-1:0] MAG_LIM  = RW'(1) << (W - 1);
  localparam logic [NW-1:0] QMAG_LIM = NW'(1) << (W - 1);

  logic signed [W-1:0] x_q, x2_q, x3_q, f_q, fd_q, t_q, u_q, g_q, h_q, q_q;
  logic signed [W-1:0] opa, opb;
  logic signed [PW-1:0] prod_q;
  logic                 mul_vld_q;
  cnrf_pkg::dst_e       mul_dst_q;
  logic                 ovf_q;

  // multiplier write-back: round half away from zero, then saturate
  logic [PW-1:0]        pm, pm_rnd;
  logic [RW-1:0]        rnd;
  logic signed [W-1:0]  mres;
  logic                 movf;

  logic signed [W:0]    asum;
  logic signed [W-1:0]  ares;
  logic                 aovf, add_en;

  logic [NW-1:0]        num_q, quo_q;
  logic [W-1:0]         rem_q, dv_q;
  logic                 neg_q;
  logic [W:0]           trial;
  logic                 take;
  logic [W-1:0]         fmag, fdmag;

  logic signed [W-1:0]  qres;
  logic                 qovf;
  logic signed [W:0]    xdiff, sdiff;
  logic signed [W-1:0]  xn;
  logic                 xovf, sovf;
  logic [W:0]           sabs;
  logic [W-2:0]         step;
  cnrf_pkg::status_e    status;

  always_comb begin
    case (cmd_i.uop.sa)
      cnrf_pkg::SRC_X:  opa = x_q;
      cnrf_pkg::SRC_X2: opa = x2_q;
      cnrf_pkg::SRC_X3: opa = x3_q;
      cnrf_pkg::SRC_F:  opa = f_q;
      cnrf_pkg::SRC_FD: opa = fd_q;
      cnrf_pkg::SRC_T:  opa = t_q;
      cnrf_pkg::SRC_U:  opa = u_q;
      cnrf_pkg::SRC_G:  opa = g_q;
      cnrf_pkg::SRC_H:  opa = h_q;
      cnrf_pkg::SRC_A:  opa = coef_cubic_i;
      cnrf_pkg::SRC_B:  opa = coef_square_i;
      cnrf_pkg::SRC_C:  opa = coef_linear_i;
      cnrf_pkg::SRC_D:  opa = coef_constant_i;
      default:          opa = '0;
    endcase
    case (cmd_i.uop.sb)
      cnrf_pkg::SRC_X:  opb = x_q;
      cnrf_pkg::SRC_X2: opb = x2_q;
      cnrf_pkg::SRC_X3: opb = x3_q;
      cnrf_pkg::SRC_F:  opb = f_q;
      cnrf_pkg::SRC_FD: opb = fd_q;
      cnrf_pkg::SRC_T:  opb = t_q;
      cnrf_pkg::SRC_U:  opb = u_q;
      cnrf_pkg::SRC_G:  opb = g_q;
      cnrf_pkg::SRC_H:  opb = h_q;
      cnrf_pkg::SRC_A:  opb = coef_cubic_i;
      cnrf_pkg::SRC_B:  opb = coef_square_i;
      cnrf_pkg::SRC_C:  opb = coef_linear_i;
      cnrf_pkg::SRC_D:  opb = coef_constant_i;
      default:          opb = '0;
    endcase
  end

  always_comb begin
    pm     = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    pm_rnd = pm + HALF;
    rnd    = pm_rnd[PW-1:FB];
    movf   = 1'b0;
    if (prod_q[PW-1]) begin
      if (rnd > MAG_LIM) begin
        movf = 1'b1;
        mres = VMIN;
      end else begin
        mres = W'(-rnd[W-1:0]);
      end
    end else if (rnd >= MAG_LIM) begin
      movf = 1'b1;
      mres = VMAX;
    end else begin
      mres = rnd[W-1:0];
    end
  end

  always_comb begin
    add_en = cmd_i.uop_en && (cmd_i.uop.kind == cnrf_pkg::UOP_ADD);
    asum   = {opa[W-1], opa} + {opb[W-1], opb};
    aovf   = asum[W] ^ asum[W-1];
    ares   = aovf ? (asum[W] ? VMIN : VMAX) : asum[W-1:0];
  end

  always_comb begin
    fmag  = f_q[W-1] ? W'(-f_q) : W'(f_q);
    fdmag = fd_q[W-1] ? W'(-fd_q) : W'(fd_q);
    trial = {rem_q, num_q[NW-1]};
    take  = (trial >= {1'b0, dv_q});
  end

  // quotient saturation
  always_comb begin
    qovf = 1'b0;
    if (neg_q) begin
      if (quo_q > QMAG_LIM) begin
        qovf = 1'b1;
        qres = VMIN;
      end else begin
        qres = W'(-quo_q[W-1:0]);
      end
    end else if (quo_q >= QMAG_LIM) begin
      qovf = 1'b1;
      qres = VMAX;
    end else begin
      qres = quo_q[W-1:0];
    end
  end

  always_comb begin
    xdiff = {x_q[W-1], x_q} - {q_q[W-1], q_q};
    xovf  = xdiff[W] ^ xdiff[W-1];
    xn    = xovf ? (xdiff[W] ? VMIN : VMAX) : xdiff[W-1:0];
    sdiff = {xn[W-1], xn} - {x_q[W-1], x_q};
    sabs  = sdiff[W] ? (W+1)'(-sdiff) : (W+1)'(sdiff);
    sovf  = (sabs > {2'b00, {(W-1){1'b1}}});
    step  = sovf ? {(W-1){1'b1}} : sabs[W-2:0];
    if (fd_q == '0) begin
      xn     = x_q;
      step   = '0;
      status = ovf_q ? cnrf_pkg::ST_OVF : cnrf_pkg::ST_ZERO;
    end else if (ovf_q || xovf || sovf) begin
      status = cnrf_pkg::ST_OVF;
    end else if (step <= step_tol_i) begin
      status = cnrf_pkg::ST_CONV;
    end else if (cmd_i.last_iter) begin
      status = cnrf_pkg::ST_LIMIT;
    end else begin
      status = cnrf_pkg::ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      mul_vld_q <= cmd_i.uop_en && (cmd_i.uop.kind == cnrf_pkg::UOP_MUL);
      if (cmd_i.load || cmd_i.advance) begin
        ovf_q <= 1'b0;
      end else begin
        ovf_q <= ovf_q | (mul_vld_q & movf) | (add_en & aovf) | (cmd_i.quot & qovf);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= opa * opb;
    mul_dst_q <= cmd_i.uop.dst;
    if (cmd_i.load) begin
      x_q <= start_x_i;
    end else if (cmd_i.advance) begin
      x_q <= x_after_o;
    end
    if (mul_vld_q) begin
      case (mul_dst_q)
        cnrf_pkg::DST_X2: x2_q <= mres;
        cnrf_pkg::DST_X3: x3_q <= mres;
        cnrf_pkg::DST_F:  f_q  <= mres;
        cnrf_pkg::DST_FD: fd_q <= mres;
        cnrf_pkg::DST_T:  t_q  <= mres;
        cnrf_pkg::DST_U:  u_q  <= mres;
        cnrf_pkg::DST_G:  g_q  <= mres;
        cnrf_pkg::DST_H:  h_q  <= mres;
        default: ;
      endcase
    end
    if (add_en) begin
      case (cmd_i.uop.dst)
        cnrf_pkg::DST_X2: x2_q <= ares;
        cnrf_pkg::DST_X3: x3_q <= ares;
        cnrf_pkg::DST_F:  f_q  <= ares;
        cnrf_pkg::DST_FD: fd_q <= ares;
        cnrf_pkg::DST_T:  t_q  <= ares;
        cnrf_pkg::DST_U:  u_q  <= ares;
        cnrf_pkg::DST_G:  g_q  <= ares;
        cnrf_pkg::DST_H:  h_q  <= ares;
        default: ;
      endcase
    end
    // restoring divide of |f| << FB by |f'|, one quotient bit a cycle
    if (cmd_i.div_start) begin
      num_q <= {fmag, {FB{1'b0}}};
      quo_q <= '0;
      rem_q <= '0;
      dv_q  <= fdmag;
      neg_q <= f_q[W-1] ^ fd_q[W-1];
    end else if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[NW-2:0], take};
      rem_q <= take ? W'(trial - {1'b0, dv_q}) : trial[W-1:0];
    end
    if (cmd_i.quot) begin
      q_q <= qres;
    end
    if (cmd_i.res) begin
      iteration_o <= cmd_i.iter;
      x_before_o  <= x_q;
      f_value_o   <= f_q;
      f_slope_o   <= fd_q;
      x_after_o   <= xn;
      step_size_o <= step;
      status_o    <= status;
    end
  end

  assign stat_o.fd_zero  = (fd_q == '0);
  assign stat_o.res_last = (status_o != cnrf_pkg::ST_RUN);

endmodule

// ===== src/cubic_newton_root_finder_top.sv =====
// Channel   | Dir | Signals                                  | Payload
// s_axis    | in  | s_axis_tvalid/tready/tdata               | start_x
// m_axis    | out | m_axis_tvalid/tready/tdata/tlast/tuser   | one result word per iteration
// apb       | in  | psel/penable/pwrite/paddr/pwdata/prdata  | six registers at 4*i
//
// Each iteration runs the shared-multiplier schedule, a check step, the bit-serial divider,
// a quotient and a result step, and then waits in the output register until the word is
// taken. A zero slope skips the divider and quotient.
// A run is up to 64 iterations; s_axis_tready is high only between runs. Reset (rst_ni
// low, asynchronous) clears control state and loads register defaults. A stalled output
// word holds until it is taken.
module cubic_newton_root_finder_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,   // [31:0] start_x
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] iteration, [37:6] x_before, [69:38] f_value, [101:70] f_slope,
  // [133:102] x_after, [164:134] step_size, [167:165] zero
  output logic [cnrf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic [2:0]                       m_axis_tuser,   // [2:0] status
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cnrf_pkg::ADDR_W-1:0]      paddr,
  input  logic [cnrf_pkg::DATA_W-1:0]      pwdata,
  output logic [cnrf_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int W = cnrf_pkg::W;

  logic signed [W-1:0]            coef_cubic_q, coef_square_q, coef_linear_q, coef_constant_q;
  logic [W-2:0]                   step_tol_q;
  logic [cnrf_pkg::LIM_W-1:0]     iter_limit_q;
  cnrf_pkg::cfg_reg_e             reg_idx;
  logic                           wr_en;

  cnrf_pkg::ctrl_cmd_t            cmd;
  cnrf_pkg::dp_stat_t             stat;
  logic [cnrf_pkg::ITER_W-1:0]    res_iter;
  logic signed [W-1:0]            res_x_before, res_f, res_fd, res_x_after;
  logic [W-2:0]                   res_step;
  cnrf_pkg::status_e              res_status;

  assign pready  = 1'b1;
  assign reg_idx = cnrf_pkg::cfg_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_cubic_q    <= '0;
      coef_square_q   <= '0;
      coef_linear_q   <= '0;
      coef_constant_q <= '0;
      step_tol_q      <= (W-1)'(1);
      iter_limit_q    <= cnrf_pkg::LIM_W'(31);
    end else if (wr_en) begin
      case (reg_idx)
        cnrf_pkg::REG_COEF_CUBIC:    coef_cubic_q    <= pwdata[W-1:0];
        cnrf_pkg::REG_COEF_SQUARE:   coef_square_q   <= pwdata[W-1:0];
        cnrf_pkg::REG_COEF_LINEAR:   coef_linear_q   <= pwdata[W-1:0];
        cnrf_pkg::REG_COEF_CONSTANT: coef_constant_q <= pwdata[W-1:0];
        cnrf_pkg::REG_STEP_TOL:      step_tol_q      <= pwdata[W-2:0];
        cnrf_pkg::REG_ITER_LIMIT:    iter_limit_q    <= pwdata[cnrf_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cnrf_pkg::REG_COEF_CUBIC:    prdata = coef_cubic_q;
      cnrf_pkg::REG_COEF_SQUARE:   prdata = coef_square_q;
      cnrf_pkg::REG_COEF_LINEAR:   prdata = coef_linear_q;
      cnrf_pkg::REG_COEF_CONSTANT: prdata = coef_constant_q;
      cnrf_pkg::REG_STEP_TOL:      prdata = {1'b0, step_tol_q};
      cnrf_pkg::REG_ITER_LIMIT:    prdata = cnrf_pkg::DATA_W'(iter_limit_q);
      default:                     prdata = '0;
    endcase
  end

  cnrf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .iter_limit_i (iter_limit_q),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  cnrf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .start_x_i       (s_axis_tdata[W-1:0]),
    .coef_cubic_i    (coef_cubic_q),
    .coef_square_i   (coef_square_q),
    .coef_linear_i   (coef_linear_q),
    .coef_constant_i (coef_constant_q),
    .step_tol_i      (step_tol_q),
    .stat_o          (stat),
    .iteration_o     (res_iter),
    .x_before_o      (res_x_before),
    .f_value_o       (res_f),
    .f_slope_o       (res_fd),
    .x_after_o       (res_x_after),
    .step_size_o     (res_step),
    .status_o        (res_status)
  );

  assign m_axis_tdata = {3'b000, res_step, res_x_after, res_fd, res_f, res_x_before, res_iter};
  assign m_axis_tlast = stat.res_last;
  assign m_axis_tuser = res_status;

endmodule

// ===== src/cnrf_checker.sv =====
`include "assert_macros.svh"

module cnrf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [cnrf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic [2:0]                       m_axis_tuser
);

  // one run at a time: no new start word while a result is shown
  `CNRF_ASSERT(a_no_overlap, !(s_axis_tready && m_axis_tvalid))

  `CNRF_ASSERT_NEXT(a_busy_after_start, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // final word exactly when status is not running
  `CNRF_ASSERT(a_last_status, !m_axis_tvalid || (m_axis_tlast == (m_axis_tuser != cnrf_pkg::ST_RUN)))

  // zero slope leaves x and reports no step
  `CNRF_ASSERT(a_zero_step, !(m_axis_tvalid && m_axis_tuser == cnrf_pkg::ST_ZERO) || (m_axis_tdata[164:134] == '0 && m_axis_tdata[37:6] == m_axis_tdata[133:102]))

  `CNRF_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind cubic_newton_root_finder_top cnrf_checker u_cnrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_cubic_newton_root_finder_top.sv =====
module tb_cubic_newton_root_finder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int WATCHDOG_CYCLES = 20000;

  typedef struct {
    logic [5:0]         iter;
    logic [31:0]        x_before;
    logic [31:0]        f_value;
    logic [31:0]        f_slope;
    logic [31:0]        x_after;
    logic [30:0]        step_size;
    logic               last;
    cnrf_pkg::status_e  st;
  } newton_step_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [31:0]                     s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [cnrf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic [2:0]                      m_axis_tuser;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [cnrf_pkg::ADDR_W-1:0]     paddr;
  logic [cnrf_pkg::DATA_W-1:0]     pwdata;
  logic [cnrf_pkg::DATA_W-1:0]     prdata;
  logic                            pready;

  // shadow of the block's registers
  longint      coef_a, coef_b, coef_c, coef_d;
  logic [30:0] tol_reg;
  logic [6:0]  lim_reg;

  newton_step_t expected_steps[$];
  int  errors;
  int  idle_cycles;
  bit  no_gaps;
  bit  hold_request;

  cubic_newton_root_finder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint pack_mag(longint unsigned r, bit neg, inout bit ovf);
    if (neg) begin
      if (r > 64'd2147483648) begin
        ovf = 1'b1;
        return SMIN;
      end
      return -longint'(r);
    end
    if (r > 64'd2147483647) begin
      ovf = 1'b1;
      return SMAX;
    end
    return longint'(r);
  endfunction

  function automatic longint qmul(longint a, longint b, inout bit ovf);
    longint unsigned ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = (ma * mb + 64'd32768) >> cnrf_pkg::FB;
    return pack_mag(p, (a < 0) != (b < 0), ovf);
  endfunction

  function automatic longint qdiv(longint n, longint d, inout bit ovf);
    longint unsigned mn, md;
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    return pack_mag((mn << cnrf_pkg::FB) / md, (n < 0) != (d < 0), ovf);
  endfunction

  function automatic longint sadd(longint a, longint b, inout bit ovf);
    longint s;
    s = a + b;
    if (s > SMAX) begin
      ovf = 1'b1;
      return SMAX;
    end
    if (s < SMIN) begin
      ovf = 1'b1;
      return SMIN;
    end
    return s;
  endfunction

  // work out every iteration of one Newton run from its start value
  function automatic void predict_newton_run(logic [31:0] start);
    int           lim;
    longint       x, x2, x3, f, fd, t, u, p, q, xn, step_mag;
    bit           ovf;
    newton_step_t r;
    lim = (lim_reg == 0) ? 1 : ((lim_reg > 64) ? 64 : int'(lim_reg));
    x = longint'($signed(start));
    for (int n = 0; n < lim; n++) begin
      ovf = 1'b0;
      x2 = qmul(x, x, ovf);
      x3 = qmul(x2, x, ovf);
      f  = qmul(coef_a, x3, ovf);
      p  = qmul(coef_b, x2, ovf);
      f  = sadd(f, p, ovf);
      p  = qmul(coef_c, x, ovf);
      f  = sadd(f, p, ovf);
      f  = sadd(f, coef_d, ovf);
      t  = qmul(coef_a, x2, ovf);
      u  = qmul(coef_b, x, ovf);
      fd = sadd(t, t, ovf);
      fd = sadd(fd, t, ovf);
      p  = sadd(u, u, ovf);
      fd = sadd(fd, p, ovf);
      fd = sadd(fd, coef_c, ovf);
      if (fd == 0) begin
        xn       = x;
        step_mag = 0;
        r.st     = ovf ? cnrf_pkg::ST_OVF : cnrf_pkg::ST_ZERO;
      end else begin
        q        = qdiv(f, fd, ovf);
        xn       = sadd(x, -q, ovf);
        step_mag = (xn >= x) ? xn - x : x - xn;
        if (step_mag > SMAX) begin
          step_mag = SMAX;
          ovf      = 1'b1;
        end
        if (ovf) r.st = cnrf_pkg::ST_OVF;
        else if (step_mag <= longint'(tol_reg)) r.st = cnrf_pkg::ST_CONV;
        else if (n + 1 == lim) r.st = cnrf_pkg::ST_LIMIT;
        else r.st = cnrf_pkg::ST_RUN;
      end
      r.iter      = n[5:0];
      r.x_before  = x[31:0];
      r.f_value   = f[31:0];
      r.f_slope   = fd[31:0];
      r.x_after   = xn[31:0];
      r.step_size = step_mag[30:0];
      r.last      = (r.st != cnrf_pkg::ST_RUN);
      expected_steps.push_back(r);
      x = xn;
      if (r.last) break;
    end
  endfunction

  task automatic send_start(logic [31:0] start);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_newton_run(start);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    // let the block settle back into idle after the last word
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(cnrf_pkg::cfg_reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      cnrf_pkg::REG_COEF_CUBIC:    coef_a  = longint'($signed(value));
      cnrf_pkg::REG_COEF_SQUARE:   coef_b  = longint'($signed(value));
      cnrf_pkg::REG_COEF_LINEAR:   coef_c  = longint'($signed(value));
      cnrf_pkg::REG_COEF_CONSTANT: coef_d  = longint'($signed(value));
      cnrf_pkg::REG_STEP_TOL:      tol_reg = value[30:0];
      cnrf_pkg::REG_ITER_LIMIT:    lim_reg = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_cubic(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    cfg_write(cnrf_pkg::REG_COEF_CUBIC, a);
    cfg_write(cnrf_pkg::REG_COEF_SQUARE, b);
    cfg_write(cnrf_pkg::REG_COEF_LINEAR, c);
    cfg_write(cnrf_pkg::REG_COEF_CONSTANT, d);
  endtask

  task automatic test_reset_defaults();
    // all coefficients zero: slope is zero straight away
    send_start(32'h0);
    send_start(32'h7fff_ffff);
    send_start(32'h8000_0000);
    wait_drained();
  endtask

  task automatic test_square_root();
    set_cubic(32'h0, 32'h0001_0000, 32'h0, 32'hfffe_0000);
    cfg_write(cnrf_pkg::REG_STEP_TOL, 32'h0);
    cfg_write(cnrf_pkg::REG_ITER_LIMIT, 32'd64);
    send_start(32'h0001_0000);
    send_start(32'hffff_0000);
    send_start(32'h0);
    send_start(32'h7fff_ffff);
    send_start(32'h8000_0000);
    wait_drained();
  endtask

  task automatic test_limit_edges();
    set_cubic(32'h0001_0000, 32'h0, 32'hffff_0000, 32'h0000_8000);
    cfg_write(cnrf_pkg::REG_STEP_TOL, 32'd1);
    cfg_write(cnrf_pkg::REG_ITER_LIMIT, 32'd0);
    send_start(32'h0003_0000);
    wait_drained();
    cfg_write(cnrf_pkg::REG_ITER_LIMIT, 32'd127);
    send_start(32'h0003_0000);
    send_start(32'hfffd_0000);
    wait_drained();
    // converged on the very last allowed iteration
    cfg_write(cnrf_pkg::REG_ITER_LIMIT, 32'd1);
    cfg_write(cnrf_pkg::REG_STEP_TOL, 32'h7fff_ffff);
    send_start(32'h0002_0000);
    wait_drained();
    cfg_write(cnrf_pkg::REG_STEP_TOL, 32'd0);
    send_start(32'h0002_0000);
    wait_drained();
  endtask

  task automatic test_overflow();
    set_cubic(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    cfg_write(cnrf_pkg::REG_ITER_LIMIT, 32'd31);
    send_start(32'h0001_0000);
    send_start(32'h7fff_ffff);
    send_start(32'h8000_0000);
    send_start(32'h0);
    wait_drained();
  endtask

  function automatic logic [31:0] rand_coef(bit wide);
    return wide ? $urandom() : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  task automatic test_random(int phases, int per_phase, bit wide);
    logic [31:0] start;
    for (int p = 0; p < phases; p++) begin
      set_cubic(rand_coef(wide), rand_coef(wide), rand_coef(wide), rand_coef(wide));
      cfg_write(cnrf_pkg::REG_STEP_TOL,
                $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 256));
      cfg_write(cnrf_pkg::REG_ITER_LIMIT, $urandom_range(0, 5) == 0 ? $urandom_range(65, 127)
                                                                    : $urandom_range(0, 64));
      for (int i = 0; i < per_phase; i++) begin
        start = ($urandom_range(0, 3) == 0) ? $urandom()
                                            : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        send_start(start);
      end
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    set_cubic(32'h0, 32'h0001_0000, 32'h0, 32'hfffd_0000);
    cfg_write(cnrf_pkg::REG_STEP_TOL, 32'd0);
    cfg_write(cnrf_pkg::REG_ITER_LIMIT, 32'd12);
    hold_request = 1'b1;
    for (int i = 0; i < 6; i++) send_start(32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
    wait_drained();
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    newton_step_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_steps.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        errors++;
      end else begin
        e = expected_steps.pop_front();
        if (m_axis_tdata[5:0] !== e.iter) begin
          $error("iteration exp %0d got %0d", e.iter, m_axis_tdata[5:0]);
          errors++;
        end
        if (m_axis_tdata[37:6] !== e.x_before) begin
          $error("x_before exp %h got %h", e.x_before, m_axis_tdata[37:6]);
          errors++;
        end
        if (m_axis_tdata[69:38] !== e.f_value) begin
          $error("f_value exp %h got %h", e.f_value, m_axis_tdata[69:38]);
          errors++;
        end
        if (m_axis_tdata[101:70] !== e.f_slope) begin
          $error("f_slope exp %h got %h", e.f_slope, m_axis_tdata[101:70]);
          errors++;
        end
        if (m_axis_tdata[133:102] !== e.x_after) begin
          $error("x_after exp %h got %h", e.x_after, m_axis_tdata[133:102]);
          errors++;
        end
        if (m_axis_tdata[164:134] !== e.step_size) begin
          $error("step_size exp %h got %h", e.step_size, m_axis_tdata[164:134]);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last exp %0b got %0b", e.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== e.st) begin
          $error("status exp %0d got %0d", e.st, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word or register access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("tb_cubic_newton_root_finder_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors        = 0;
    idle_cycles   = 0;
    no_gaps       = 1'b0;
    hold_request  = 1'b0;
    coef_a        = 0;
    coef_b        = 0;
    coef_c        = 0;
    coef_d        = 0;
    tol_reg       = 31'd1;
    lim_reg       = 7'd31;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_square_root();
    test_limit_edges();
    test_overflow();
    test_backpressure();
    test_random(7, 24, 1'b0);
    test_random(2, 12, 1'b1);
    no_gaps = 1'b1;
    test_random(2, 12, 1'b0);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("tb_cubic_newton_root_finder_top OK");
    end else begin
      $display("tb_cubic_newton_root_finder_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== cubic_newton_root_finder_top.f =====
+incdir+src
src/cnrf_pkg.sv
src/cnrf_ctrl.sv
src/cnrf_dp.sv
src/cubic_newton_root_finder_top.sv
src/cnrf_checker.sv
verif/tb_cubic_newton_root_finder_top.sv
